[src/opl_pkg.sv]
// opl_pkg: types and constants of the paragraph line breaker
// depends on nothing; used by every module of the block but opl_ram
`default_nettype none
package opl_pkg;

    localparam int LEN_W      = 10;
    localparam int SPACE_W    = 8;
    localparam int FLAG_W     = 4;
    localparam int INDENT_W   = 8;
    localparam int LINE_W     = 12;
    localparam int CFG_W      = 10;
    localparam int COST_W     = 64;
    localparam int OUT_START_W = 6;
    localparam int DIFF_W     = 14;
    localparam int SQ_W       = 27;
    localparam int SCL_W      = 34;
    localparam int TSUM_W     = 36;
    localparam int FX_W       = 21;
    localparam int DIV_W      = 16;
    localparam int DVS_W      = 11;

    // flag bits in the flag store
    localparam int FL_PAREN  = 0;
    localparam int FL_PERIOD = 1;
    localparam int FL_PUNCT  = 2;
    localparam int FL_FINAL  = 3;
    localparam logic [FLAG_W-1:0] FL_END_MARKS = 4'b1010;

    localparam logic CFG_MAX_WIDTH    = 1'b0;
    localparam logic CFG_TARGET_WIDTH = 1'b1;
    localparam logic [CFG_W-1:0] MAX_WIDTH_RESET    = 10'd75;
    localparam logic [CFG_W-1:0] TARGET_WIDTH_RESET = 10'd70;

    localparam logic signed [FX_W-1:0] FX_LINE       = 21'sd4900;
    localparam logic signed [FX_W-1:0] FX_SENT_END   = -21'sd2500;
    localparam logic signed [FX_W-1:0] FX_NO_BREAK   = 21'sd360000;
    localparam logic signed [FX_W-1:0] FX_PUNCT      = -21'sd1600;
    localparam logic signed [FX_W-1:0] FX_PAREN      = -21'sd1600;
    localparam logic [DIV_W-1:0] ORPHAN_NUM = 16'd40000;
    localparam logic [DIV_W-1:0] WIDOW_NUM  = 16'd22500;

    localparam logic signed [COST_W-1:0] COST_MAX = {1'b0, {(COST_W-1){1'b1}}};

    typedef enum logic [4:0] {
        ST_IDLE, ST_INIT, ST_F0, ST_F1, ST_F2, ST_F3,
        ST_DA_GO, ST_DA_W, ST_DB_GO, ST_DB_W, ST_FIX,
        ST_RD, ST_SQ, ST_SCL, ST_SUM, ST_ADD, ST_NEXT, ST_WB,
        ST_E_RD, ST_E_CAP, ST_E_LOAD
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_INIT, OP_F0, OP_F1, OP_F2, OP_F3,
        OP_DA_GO, OP_DA_W, OP_DB_GO, OP_DB_W, OP_FIX,
        OP_RD, OP_SQ, OP_SCL, OP_SUM, OP_ADD, OP_NEXT, OP_WB,
        OP_E_RD, OP_E_CAP, OP_E_LOAD
    } op_t;

    typedef struct packed {
        logic take;
        op_t  op;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic cont;
        logic s_zero;
        logic e_done;
        logic slot_free;
    } dp_stat_t;

endpackage
`default_nettype wire

[src/optimal_paragraph_line_breaker.sv]
// optimal_paragraph_line_breaker: top level of the paragraph line breaker
// depends on opl_pkg, opl_ctrl and opl_datapath
//
// Words arrive on the input channel (in_valid / in_stall), one per word,
// indents and prior line length taken from the first word of a paragraph.
// A word with last_word set ends the paragraph and starts the cost search.
// Lines leave on the output channel (out_valid / out_stall), one per transfer,
// in order, the final one flagged by last_line.
// Loading: one word per cycle while the block is idle.
// Search: a start step, then for each word the fetch and the two divides of
// the fixed cost, plus the read, square, scale, sum, add and next steps per
// candidate break; the candidates per word are the words that fit on one line.
// Output: a line is read, captured, then loaded once out_stall frees the register.
// in_stall is high from the last word until the last line is loaded.
// The configuration port writes max_line_width (0) and target_line_width (1)
// at any enabled edge; it is meant to be used while the block is idle.
// Reset clears the word count, the output valid and the state machine and
// restores the widths to 75 and 70.
`default_nettype none
module optimal_paragraph_line_breaker #(
    parameter int WORD_CAPACITY = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic                           cfg_index,
    input  wire logic [opl_pkg::CFG_W-1:0]      cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [opl_pkg::LEN_W-1:0]      word_length,
    input  wire logic [opl_pkg::SPACE_W-1:0]    space_after,
    input  wire logic                           opens_paren,
    input  wire logic                           ends_period,
    input  wire logic                           ends_punct,
    input  wire logic                           ends_sentence,
    input  wire logic [opl_pkg::INDENT_W-1:0]   first_line_indent,
    input  wire logic [opl_pkg::INDENT_W-1:0]   later_line_indent,
    input  wire logic [opl_pkg::LINE_W-1:0]     prior_line_length,
    input  wire logic                           last_word,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [opl_pkg::OUT_START_W-1:0]     line_start_word,
    output logic [opl_pkg::LINE_W-1:0]          line_columns,
    output logic signed [opl_pkg::COST_W-1:0]   paragraph_cost,
    output logic                                words_dropped,
    output logic                                last_line
);
    import opl_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    opl_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .last_word(last_word),
        .stat(stat), .cmd(cmd), .in_stall(in_stall));

    opl_datapath #(.WORD_CAPACITY(WORD_CAPACITY)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .word_length(word_length), .space_after(space_after),
        .opens_paren(opens_paren), .ends_period(ends_period),
        .ends_punct(ends_punct), .ends_sentence(ends_sentence),
        .first_line_indent(first_line_indent), .later_line_indent(later_line_indent),
        .prior_line_length(prior_line_length), .last_word(last_word),
        .out_stall(out_stall), .out_valid(out_valid),
        .line_start_word(line_start_word), .line_columns(line_columns),
        .paragraph_cost(paragraph_cost), .words_dropped(words_dropped),
        .last_line(last_line));
endmodule
`default_nettype wire

[src/opl_ram.sv]
// opl_ram: generic simple dual-port ram with registered read
// no dependencies
`default_nettype none
module opl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[src/opl_divider.sv]
// opl_divider: restoring divider, one quotient bit per cycle
// depends on opl_pkg
`default_nettype none
module opl_divider (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [opl_pkg::DIV_W-1:0]  dividend,
    input  wire logic [opl_pkg::DVS_W-1:0]  divisor,
    output logic                            done,
    output logic [opl_pkg::DIV_W-1:0]       quotient
);
    import opl_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W:0]   rem_reg, rem_next;
    logic [DIV_W-1:0] dq_reg, dq_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DIV_W:0]   trial;
    logic             ge;

    assign trial = {rem_reg[DIV_W-1:0], dq_reg[DIV_W-1]};
    assign ge    = trial >= (DIV_W+1)'(dvs_reg);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dq_next   = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? trial - (DIV_W+1)'(dvs_reg) : trial;
            dq_next  = {dq_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_W-1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = dq_reg;
endmodule
`default_nettype wire

[src/opl_ctrl.sv]
// opl_ctrl: sequencer for loading, the backward cost search and line output
// depends on opl_pkg
`default_nettype none
module opl_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              last_word,
    input  wire opl_pkg::dp_stat_t stat,
    output opl_pkg::dp_cmd_t       cmd,
    output logic                   in_stall
);
    import opl_pkg::*;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid && last_word) state_next = ST_INIT;
            ST_INIT:   state_next = ST_F0;
            ST_F0:     state_next = ST_F1;
            ST_F1:     state_next = ST_F2;
            ST_F2:     state_next = ST_F3;
            ST_F3:     state_next = ST_DA_GO;
            ST_DA_GO:  state_next = ST_DA_W;
            ST_DA_W:   if (stat.div_done) state_next = ST_DB_GO;
            ST_DB_GO:  state_next = ST_DB_W;
            ST_DB_W:   if (stat.div_done) state_next = ST_FIX;
            ST_FIX:    state_next = ST_RD;
            ST_RD:     state_next = ST_SQ;
            ST_SQ:     state_next = ST_SCL;
            ST_SCL:    state_next = ST_SUM;
            ST_SUM:    state_next = ST_ADD;
            ST_ADD:    state_next = ST_NEXT;
            ST_NEXT:   state_next = stat.cont ? ST_RD : ST_WB;
            ST_WB:     state_next = stat.s_zero ? ST_E_RD : ST_F0;
            ST_E_RD:   state_next = ST_E_CAP;
            ST_E_CAP:  state_next = ST_E_LOAD;
            ST_E_LOAD: if (stat.slot_free) state_next = stat.e_done ? ST_IDLE : ST_E_RD;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.take = 1'b0;
        cmd.op   = OP_NONE;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.take = in_valid;
            end
            ST_INIT:   cmd.op = OP_INIT;
            ST_F0:     cmd.op = OP_F0;
            ST_F1:     cmd.op = OP_F1;
            ST_F2:     cmd.op = OP_F2;
            ST_F3:     cmd.op = OP_F3;
            ST_DA_GO:  cmd.op = OP_DA_GO;
            ST_DA_W:   cmd.op = OP_DA_W;
            ST_DB_GO:  cmd.op = OP_DB_GO;
            ST_DB_W:   cmd.op = OP_DB_W;
            ST_FIX:    cmd.op = OP_FIX;
            ST_RD:     cmd.op = OP_RD;
            ST_SQ:     cmd.op = OP_SQ;
            ST_SCL:    cmd.op = OP_SCL;
            ST_SUM:    cmd.op = OP_SUM;
            ST_ADD:    cmd.op = OP_ADD;
            ST_NEXT:   cmd.op = OP_NEXT;
            ST_WB:     cmd.op = OP_WB;
            ST_E_RD:   cmd.op = OP_E_RD;
            ST_E_CAP:  cmd.op = OP_E_CAP;
            ST_E_LOAD: cmd.op = OP_E_LOAD;
            default:   cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_div_wait_has_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DA_W || state_reg == ST_DB_W) |-> !cmd.take)
        else $error("word taken during divide");
    a_stall_outside_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall)
        else $error("input open while busy");
    a_last_starts_solve: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take && last_word) |=> (state_reg == ST_INIT))
        else $error("last word did not start the search");
endmodule
`default_nettype wire

[src/opl_datapath.sv]
// opl_datapath: word stores, cost search arithmetic and output register
// depends on opl_pkg, opl_ram and opl_divider
`default_nettype none
module opl_datapath #(
    parameter int WORD_CAPACITY = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire opl_pkg::dp_cmd_t               cmd,
    output opl_pkg::dp_stat_t                   stat,
    input  wire logic                           cfg_write,
    input  wire logic                           cfg_index,
    input  wire logic [opl_pkg::CFG_W-1:0]      cfg_data,
    input  wire logic [opl_pkg::LEN_W-1:0]      word_length,
    input  wire logic [opl_pkg::SPACE_W-1:0]    space_after,
    input  wire logic                           opens_paren,
    input  wire logic                           ends_period,
    input  wire logic                           ends_punct,
    input  wire logic                           ends_sentence,
    input  wire logic [opl_pkg::INDENT_W-1:0]   first_line_indent,
    input  wire logic [opl_pkg::INDENT_W-1:0]   later_line_indent,
    input  wire logic [opl_pkg::LINE_W-1:0]     prior_line_length,
    input  wire logic                           last_word,
    input  wire logic                           out_stall,
    output logic                                out_valid,
    output logic [opl_pkg::OUT_START_W-1:0]     line_start_word,
    output logic [opl_pkg::LINE_W-1:0]          line_columns,
    output logic signed [opl_pkg::COST_W-1:0]   paragraph_cost,
    output logic                                words_dropped,
    output logic                                last_line
);
    import opl_pkg::*;

    localparam int AW = $clog2(WORD_CAPACITY);
    localparam int IW = $clog2(WORD_CAPACITY + 1);

    // configuration
    logic [CFG_W-1:0] max_reg, target_reg;

    // paragraph state
    logic [IW-1:0]       count_reg;
    logic                ovf_reg;
    logic [INDENT_W-1:0] first_ind_reg, later_ind_reg;
    logic [LINE_W-1:0]   prior_reg;
    logic [FLAG_W-1:0]   last_flags_reg;

    // search registers
    logic [IW-1:0]       s_reg, w_reg;
    logic [FLAG_W-1:0]   flag_s_reg, flag_p_reg, flag_pp_reg;
    logic [LEN_W-1:0]    len_s_reg, len_p_reg;
    logic [DIV_W-1:0]    qa_reg, qb_reg;
    logic signed [FX_W-1:0] fix_reg;
    logic [LINE_W-1:0]   len_reg;
    logic signed [COST_W-1:0] best_reg, suf_w_reg, total_reg;
    logic [IW-1:0]       brk_reg, brk_w_reg, nx_reg;
    logic [LINE_W-1:0]   blen_reg, bl_out_reg;
    logic [SPACE_W-1:0]  sp_w_reg;
    logic [LEN_W-1:0]    lw_w_reg;
    logic [SQ_W-1:0]     sq1_reg, sq2_reg, sq3_reg;
    logic [SCL_W-1:0]    t1_reg, t2_reg, t3_reg;
    logic [TSUM_W-1:0]   tsum_reg;

    // output register
    logic                    out_valid_reg;
    logic [OUT_START_W-1:0]  out_start_reg;
    logic [LINE_W-1:0]       out_len_reg;
    logic signed [COST_W-1:0] out_cost_reg;
    logic                    out_drop_reg, out_last_reg;

    // ram ports
    logic              len_we, sp_we, fl_we, suf_we, brk_we;
    logic [AW-1:0]     len_wa, fl_wa, len_ra, sp_ra, fl_ra, brk_ra, brk_wa;
    logic [IW-1:0]     suf_wa, suf_ra;
    logic [FLAG_W-1:0] fl_wd, fl_rd, in_flags;
    logic [LEN_W-1:0]  len_rd;
    logic [SPACE_W-1:0] sp_rd;
    logic signed [COST_W-1:0] suf_wd, suf_rd;
    logic [IW-1:0]     brk_rd;
    logic [LINE_W-1:0] blen_rd;

    logic              div_start, div_done;
    logic [DIV_W-1:0]  div_dividend, div_q;
    logic [DVS_W-1:0]  div_divisor;

    logic              stored, slot_free;
    logic [IW-1:0]     s_m1, s_m2, w_m1;
    logic [LINE_W:0]   len_add;
    logic signed [DIFF_W-1:0] d1, d2, d3;
    logic signed [2*DIFF_W-1:0] p1, p2, p3;
    logic signed [COST_W-1:0] wc;
    logic signed [FX_W-1:0] fx;

    assign stored   = count_reg < IW'(WORD_CAPACITY);
    assign in_flags = {ends_sentence, ends_punct, ends_period, opens_paren};
    assign s_m1     = s_reg - IW'(1);
    assign s_m2     = s_reg - IW'(2);
    assign w_m1     = w_reg - IW'(1);
    assign slot_free = !out_valid_reg || !out_stall;
    assign len_add  = {1'b0, len_reg} + (LINE_W+1)'(sp_w_reg) + (LINE_W+1)'(lw_w_reg);

    assign d1 = $signed(DIFF_W'(target_reg)) - $signed(DIFF_W'(len_reg));
    assign d2 = $signed(DIFF_W'(len_reg)) - $signed(DIFF_W'(blen_rd));
    assign d3 = $signed(DIFF_W'(len_reg)) - $signed(DIFF_W'(prior_reg));
    assign p1 = d1 * d1;
    assign p2 = d2 * d2;
    assign p3 = d3 * d3;
    assign wc = suf_w_reg + $signed(COST_W'(tsum_reg));

    opl_ram #(.WIDTH(LEN_W), .DEPTH(WORD_CAPACITY)) u_len_ram (
        .clk(clk), .we(len_we), .waddr(len_wa), .wdata(word_length),
        .raddr(len_ra), .rdata(len_rd));
    opl_ram #(.WIDTH(SPACE_W), .DEPTH(WORD_CAPACITY)) u_space_ram (
        .clk(clk), .we(sp_we), .waddr(len_wa), .wdata(space_after),
        .raddr(sp_ra), .rdata(sp_rd));
    opl_ram #(.WIDTH(FLAG_W), .DEPTH(WORD_CAPACITY)) u_flag_ram (
        .clk(clk), .we(fl_we), .waddr(fl_wa), .wdata(fl_wd),
        .raddr(fl_ra), .rdata(fl_rd));
    opl_ram #(.WIDTH(COST_W), .DEPTH(WORD_CAPACITY + 1)) u_suffix_ram (
        .clk(clk), .we(suf_we), .waddr(suf_wa), .wdata(suf_wd),
        .raddr(suf_ra), .rdata(suf_rd));
    opl_ram #(.WIDTH(IW), .DEPTH(WORD_CAPACITY)) u_break_ram (
        .clk(clk), .we(brk_we), .waddr(brk_wa), .wdata(brk_reg),
        .raddr(brk_ra), .rdata(brk_rd));
    opl_ram #(.WIDTH(LINE_W), .DEPTH(WORD_CAPACITY)) u_best_len_ram (
        .clk(clk), .we(brk_we), .waddr(brk_wa), .wdata(blen_reg),
        .raddr(brk_ra), .rdata(blen_rd));

    opl_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dividend),
        .divisor(div_divisor), .done(div_done), .quotient(div_q));

    // ram address and write control
    always_comb
    begin
        len_we = cmd.take && stored;
        sp_we  = cmd.take && stored;
        len_wa = count_reg[AW-1:0];
        fl_we  = cmd.take && (stored || last_word);
        fl_wa  = stored ? count_reg[AW-1:0] : AW'(WORD_CAPACITY - 1);
        fl_wd  = (stored ? in_flags : last_flags_reg) | (last_word ? FL_END_MARKS : '0);
        len_ra = s_reg[AW-1:0];
        fl_ra  = s_reg[AW-1:0];
        sp_ra  = w_m1[AW-1:0];
        brk_ra = w_reg[AW-1:0];
        suf_ra = w_reg;
        suf_we = 1'b0;
        suf_wa = s_reg;
        suf_wd = best_reg + COST_W'(fix_reg);
        brk_we = 1'b0;
        brk_wa = s_reg[AW-1:0];
        div_start    = 1'b0;
        div_dividend = ORPHAN_NUM;
        div_divisor  = DVS_W'(len_p_reg) + DVS_W'(2);
        unique case (cmd.op)
            OP_INIT:
            begin
                suf_we = 1'b1;
                suf_wa = count_reg;
                suf_wd = '0;
            end
            OP_F1:
            begin
                len_ra = s_m1[AW-1:0];
                fl_ra  = s_m1[AW-1:0];
            end
            OP_F2:   fl_ra = s_m2[AW-1:0];
            OP_DA_GO: div_start = 1'b1;
            OP_DB_GO:
            begin
                div_start    = 1'b1;
                div_dividend = WIDOW_NUM;
                div_divisor  = DVS_W'(len_s_reg) + DVS_W'(2);
            end
            OP_RD:   len_ra = w_reg[AW-1:0];
            OP_WB:
            begin
                suf_we = 1'b1;
                brk_we = 1'b1;
            end
            OP_E_RD: brk_ra = s_reg[AW-1:0];
            default: ;
        endcase
    end

    // fixed part of the line cost
    always_comb
    begin
        fx = FX_LINE;
        if (s_reg != '0)
        begin
            priority if (flag_p_reg[FL_PERIOD])
                fx = fx + (flag_p_reg[FL_FINAL] ? FX_SENT_END : FX_NO_BREAK);
            else if (flag_p_reg[FL_PUNCT])
                fx = fx + FX_PUNCT;
            else if (s_reg != IW'(1) && flag_pp_reg[FL_FINAL])
                fx = fx + $signed(FX_W'(qa_reg));
        end
        priority if (flag_s_reg[FL_PAREN])
            fx = fx + FX_PAREN;
        else if (flag_s_reg[FL_FINAL])
            fx = fx + $signed(FX_W'(qb_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg       <= MAX_WIDTH_RESET;
            target_reg    <= TARGET_WIDTH_RESET;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            first_ind_reg <= '0;
            later_ind_reg <= '0;
            prior_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_MAX_WIDTH:    max_reg <= cfg_data;
                    CFG_TARGET_WIDTH: target_reg <= cfg_data;
                    default:          ;
                endcase
            end
            if (cmd.take)
            begin
                if (count_reg == '0)
                begin
                    first_ind_reg <= first_line_indent;
                    later_ind_reg <= later_line_indent;
                    prior_reg     <= prior_line_length;
                end
                if (stored)
                    count_reg <= count_reg + IW'(1);
                else
                    ovf_reg <= 1'b1;
            end
            if (cmd.op == OP_E_LOAD && slot_free)
            begin
                out_valid_reg <= 1'b1;
                if (stat.e_done)
                begin
                    count_reg     <= '0;
                    ovf_reg       <= 1'b0;
                    first_ind_reg <= '0;
                    later_ind_reg <= '0;
                    prior_reg     <= '0;
                end
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take && stored)
            last_flags_reg <= in_flags;
        unique case (cmd.op)
            OP_INIT: s_reg <= count_reg - IW'(1);
            OP_F1:
            begin
                flag_s_reg <= fl_rd;
                len_s_reg  <= len_rd;
            end
            OP_F2:
            begin
                flag_p_reg <= fl_rd;
                len_p_reg  <= len_rd;
            end
            OP_F3:
            begin
                flag_pp_reg <= fl_rd;
                len_reg  <= LINE_W'(s_reg == '0 ? first_ind_reg : later_ind_reg)
                            + LINE_W'(len_s_reg);
                w_reg    <= s_reg + IW'(1);
                best_reg <= COST_MAX;
            end
            OP_DA_W: if (div_done) qa_reg <= div_q;
            OP_DB_W: if (div_done) qb_reg <= div_q;
            OP_FIX:  fix_reg <= fx;
            OP_SQ:
            begin
                suf_w_reg <= suf_rd;
                brk_w_reg <= brk_rd;
                sp_w_reg  <= sp_rd;
                lw_w_reg  <= len_rd;
                sq1_reg   <= SQ_W'(p1);
                sq2_reg   <= SQ_W'(p2);
                sq3_reg   <= SQ_W'(p3);
            end
            OP_SCL:
            begin
                t1_reg <= (w_reg != count_reg) ? SCL_W'(sq1_reg) * SCL_W'(100) : '0;
                t2_reg <= (w_reg != count_reg && brk_w_reg != count_reg)
                          ? (SCL_W'(sq2_reg) * SCL_W'(100)) >> 1 : '0;
                t3_reg <= (s_reg == '0 && prior_reg != '0)
                          ? (SCL_W'(sq3_reg) * SCL_W'(100)) >> 1 : '0;
            end
            OP_SUM:  tsum_reg <= TSUM_W'(t1_reg) + TSUM_W'(t2_reg) + TSUM_W'(t3_reg);
            OP_ADD:
            begin
                if (wc < best_reg)
                begin
                    best_reg <= wc;
                    brk_reg  <= w_reg;
                    blen_reg <= len_reg;
                end
            end
            OP_NEXT:
            begin
                len_reg <= len_add[LINE_W-1:0];
                w_reg   <= w_reg + IW'(1);
            end
            OP_WB:
            begin
                if (s_reg == '0)
                    total_reg <= suf_wd;
                else
                    s_reg <= s_m1;
            end
            OP_E_CAP:
            begin
                nx_reg     <= brk_rd;
                bl_out_reg <= blen_rd;
            end
            OP_E_LOAD:
            begin
                if (slot_free)
                begin
                    out_start_reg <= OUT_START_W'(s_reg);
                    out_len_reg   <= bl_out_reg;
                    out_cost_reg  <= total_reg;
                    out_drop_reg  <= ovf_reg;
                    out_last_reg  <= nx_reg >= count_reg;
                    s_reg         <= nx_reg;
                end
            end
            default: ;
        endcase
    end

    assign stat.div_done  = div_done;
    assign stat.cont      = (w_reg < count_reg) && (len_add < (LINE_W+1)'(max_reg));
    assign stat.s_zero    = s_reg == '0;
    assign stat.e_done    = (nx_reg <= s_reg) || (nx_reg >= count_reg);
    assign stat.slot_free = slot_free;

    assign out_valid       = out_valid_reg;
    assign line_start_word = out_start_reg;
    assign line_columns    = out_len_reg;
    assign paragraph_cost  = out_cost_reg;
    assign words_dropped   = out_drop_reg;
    assign last_line       = out_last_reg;

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= IW'(WORD_CAPACITY))
        else $error("word count beyond capacity");
    a_candidate_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_ADD) |-> (w_reg > s_reg && w_reg <= count_reg))
        else $error("candidate break out of range");
    a_break_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_WB) |-> (brk_reg > s_reg))
        else $error("chosen break does not advance");
    a_emit_stays_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_E_LOAD && slot_free) |=> out_valid_reg)
        else $error("line lost at output");
endmodule
`default_nettype wire
